// File: design/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcgr_pkg;

    // Character codes and item kinds
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_DRAW  = 1'b1;

    // Column limit is screen width minus this many glyph widths
    localparam int COL_MARGIN_GLYPHS = 22;
    // 32-bit pixels: byte offset of a pixel is its index shifted by two
    localparam int PIXEL_SHIFT = 2;
    // Width of a font store offset before reduction (glyph * stride or load address)
    localparam int OFFSET_W = 14;

    // Register reset values
    localparam logic [31:0] RST_FB_BASE = 32'd0;
    localparam logic [11:0] RST_SCR_W   = 12'd1024;
    localparam logic [11:0] RST_SCR_H   = 12'd768;
    localparam logic [13:0] RST_PITCH   = 14'd4096;
    localparam logic [3:0]  RST_GLYPH_W = 4'd8;
    localparam logic [5:0]  RST_GLYPH_H = 6'd16;
    localparam logic [8:0]  RST_GCOUNT  = 9'd256;
    localparam logic [5:0]  RST_GSTRIDE = 6'd16;

    typedef enum logic [2:0] {
        CFG_FB_BASE  = 3'd0,
        CFG_SCR_W    = 3'd1,
        CFG_SCR_H    = 3'd2,
        CFG_PITCH    = 3'd3,
        CFG_GLYPH_W  = 3'd4,
        CFG_GLYPH_H  = 3'd5,
        CFG_GCOUNT   = 3'd6,
        CFG_GSTRIDE  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic [12:0] store_addr;
        logic [7:0]  store_byte;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] row_address;
        logic [7:0]  row_bits;
        logic        last;
        logic [11:0] cursor_col;
        logic [11:0] cursor_row;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mod_step;
        logic mem_we;
        logic mul;
        logic base;
        logic cursor;
        logic prefetch;
        logic advance;
        logic show_write;
        logic show_resp;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic step_zero;
        logic is_load;
        logic is_ctrl;
        logic rows_zero;
        logic last_row;
    } t_status;

    // Pixel mask for a glyph width (white where a bit is set)
    function automatic logic [7:0] glyph_mask(input logic [3:0] gw);
        logic [7:0] m;
        if (gw == 4'd0) begin
            m = 8'h00;
        end else if (gw >= 4'd8) begin
            m = 8'hFF;
        end else begin
            m = 8'((9'd1 << gw) - 9'd1);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: design/tcgr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tcgr_ctrl
    import tcgr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MOD  = 9'b000000010,
        S_WR   = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_BASE = 9'b000010000,
        S_CURS = 9'b000100000,
        S_PRE  = 9'b001000000,
        S_EMIT = 9'b010000000,
        S_RESP = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.step_zero) begin
                    if (i_status.is_load) begin
                        n_state = S_WR;
                    end else if (i_status.is_ctrl) begin
                        n_state = S_CURS;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_WR: begin
                o_cmd.mem_we = 1'b1;
                n_state      = S_RESP;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_CURS;
            end
            S_CURS: begin
                o_cmd.cursor = 1'b1;
                if (i_status.is_ctrl || i_status.rows_zero) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.prefetch = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.show_write = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            S_RESP: begin
                o_cmd.show_resp = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT) || (r_state == S_RESP);

endmodule
`default_nettype wire

// File: design/tcgr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module tcgr_dpath
    import tcgr_pkg::*;
#(
    parameter int FONT_STORE_BYTES = 8192,
    parameter int MAX_GLYPH_ROWS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire t_in_item    i_item,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output t_out_item        o_item
);

    localparam int AW        = $clog2(FONT_STORE_BYTES);
    // enough restoring steps to bring any offset below the store size
    localparam int MOD_STEPS = $clog2((1 << OFFSET_W) / FONT_STORE_BYTES + 2);
    localparam int SCW       = $clog2(MOD_STEPS + 1);
    localparam int CW        = $clog2(FONT_STORE_BYTES + 1) + MOD_STEPS;
    localparam int RW        = $clog2(MAX_GLYPH_ROWS + 1);

    // Configuration registers
    logic [31:0] r_fb_base;
    logic [11:0] r_scr_w;
    logic [11:0] r_scr_h;
    logic [13:0] r_pitch;
    logic [3:0]  r_gw;
    logic [5:0]  r_gh;
    logic [8:0]  r_gcount;
    logic [5:0]  r_gstride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_base <= RST_FB_BASE;
            r_scr_w   <= RST_SCR_W;
            r_scr_h   <= RST_SCR_H;
            r_pitch   <= RST_PITCH;
            r_gw      <= RST_GLYPH_W;
            r_gh      <= RST_GLYPH_H;
            r_gcount  <= RST_GCOUNT;
            r_gstride <= RST_GSTRIDE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FB_BASE: r_fb_base <= i_cfg_data;
                CFG_SCR_W:   r_scr_w   <= i_cfg_data[11:0];
                CFG_SCR_H:   r_scr_h   <= i_cfg_data[11:0];
                CFG_PITCH:   r_pitch   <= i_cfg_data[13:0];
                CFG_GLYPH_W: r_gw      <= i_cfg_data[3:0];
                CFG_GLYPH_H: r_gh      <= i_cfg_data[5:0];
                CFG_GCOUNT:  r_gcount  <= i_cfg_data[8:0];
                CFG_GSTRIDE: r_gstride <= i_cfg_data[5:0];
            endcase
        end
    end

    // Request registers and store offset reduction
    logic                r_kind;
    logic [7:0]          r_code;
    logic [7:0]          r_store_byte;
    logic [OFFSET_W-1:0] r_mod;
    logic [SCW-1:0]      r_step;
    logic [7:0]          w_glyph;
    logic [CW-1:0]       w_mod_div;
    logic                w_mod_ge;

    assign w_glyph   = (9'(i_item.char_code) < r_gcount) ? i_item.char_code : 8'd0;
    assign w_mod_div = CW'(FONT_STORE_BYTES) << r_step;
    assign w_mod_ge  = CW'(r_mod) >= w_mod_div;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind       <= i_item.kind;
            r_code       <= i_item.char_code;
            r_store_byte <= i_item.store_byte;
            r_step       <= SCW'(MOD_STEPS - 1);
            if (i_item.kind == KIND_LOAD) begin
                r_mod <= OFFSET_W'(i_item.store_addr);
            end else begin
                r_mod <= OFFSET_W'(OFFSET_W'(w_glyph) * OFFSET_W'(r_gstride));
            end
        end else if (i_cmd.mod_step) begin
            r_step <= r_step - SCW'(1);
            if (w_mod_ge) begin
                r_mod <= r_mod - OFFSET_W'(w_mod_div);
            end
        end
    end

    logic w_is_load, w_is_cr, w_is_lf;
    assign w_is_load = (r_kind == KIND_LOAD);
    assign w_is_cr   = (r_kind == KIND_DRAW) && (r_code == CHAR_CR);
    assign w_is_lf   = (r_kind == KIND_DRAW) && (r_code == CHAR_LF);

    // Cell address: base + row * height * pitch + col * (width + 1) * 4
    logic [4:0]  w_gw1;
    logic [17:0] r_prod_rg;
    logic [18:0] r_coloff;
    logic [31:0] r_addr;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] w_idx_next;
    logic [RW-1:0] r_j;
    logic [RW-1:0] w_rows;
    logic [11:0] r_col, r_row;

    assign w_gw1      = {1'b0, r_gw} + 5'd1;
    assign w_idx_next = (r_idx == AW'(FONT_STORE_BYTES - 1)) ? '0 : r_idx + AW'(1);
    assign w_rows     = (int'(r_gh) < MAX_GLYPH_ROWS) ? RW'(r_gh) : RW'(MAX_GLYPH_ROWS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_rg <= 18'(r_row) * 18'(r_gh);
            r_coloff  <= 19'(19'(r_col) * 19'(w_gw1)) << PIXEL_SHIFT;
            r_idx     <= AW'(r_mod);
            r_j       <= '0;
        end else if (i_cmd.base) begin
            r_addr <= r_fb_base + 32'(32'(r_prod_rg) * 32'(r_pitch)) + 32'(r_coloff);
        end else if (i_cmd.advance) begin
            r_addr <= r_addr + 32'(r_pitch);
            r_idx  <= w_idx_next;
            r_j    <= r_j + RW'(1);
        end
    end

    // Cursor advance and wrap limits (unsigned: a negative limit never trips)
    logic [11:0] w_col_inc, w_row_inc, w_row_next;
    logic [16:0] w_col_prod, w_col_marg;
    logic [17:0] w_row_prod;
    logic        w_col_wrap, w_row_wrap;
    logic [11:0] n_col, n_row;

    assign w_col_inc  = r_col + 12'd1;
    assign w_row_inc  = r_row + 12'd1;
    assign w_col_prod = 17'(w_col_inc) * 17'(w_gw1);
    assign w_col_marg = 17'(r_gw) * 17'(COL_MARGIN_GLYPHS);
    assign w_col_wrap = (17'(r_scr_w) >= w_col_marg)
                     && (w_col_prod > (17'(r_scr_w) - w_col_marg));
    assign w_row_prod = 18'(w_row_inc) * 18'(r_gh);
    assign w_row_wrap = (r_scr_h >= 12'(r_gh))
                     && (w_row_prod > 18'(r_scr_h - 12'(r_gh)));
    assign w_row_next = w_row_wrap ? 12'd0 : w_row_inc;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.cursor) begin
            priority if (w_is_cr) begin
                n_col = 12'd0;
            end else if (w_is_lf || w_col_wrap) begin
                n_col = 12'd0;
                n_row = w_row_next;
            end else begin
                n_col = w_col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 12'd0;
            r_row <= 12'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Font store: one write port, one registered read port
    logic [7:0]    r_font [FONT_STORE_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_en;

    assign w_rd_en   = i_cmd.prefetch || i_cmd.advance;
    assign w_rd_addr = i_cmd.advance ? w_idx_next : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_font[AW'(r_mod)] <= r_store_byte;
        end
        if (w_rd_en) begin
            r_rdata <= r_font[w_rd_addr];
        end
    end

    // Status and result
    logic w_last_row;
    assign w_last_row = (r_j == w_rows - RW'(1));

    assign o_status.step_zero = (r_step == '0);
    assign o_status.is_load   = w_is_load;
    assign o_status.is_ctrl   = w_is_cr || w_is_lf;
    assign o_status.rows_zero = (w_rows == '0);
    assign o_status.last_row  = w_last_row;

    assign o_item.write_valid = i_cmd.show_write;
    assign o_item.row_address = i_cmd.show_write ? r_addr : 32'd0;
    assign o_item.row_bits    = i_cmd.show_write ? (r_rdata & glyph_mask(r_gw)) : 8'd0;
    assign o_item.last        = i_cmd.show_resp || (i_cmd.show_write && w_last_row);
    assign o_item.cursor_col  = r_col;
    assign o_item.cursor_row  = r_row;

endmodule
`default_nettype wire

// File: design/text_console_glyph_renderer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Text console glyph renderer. Font bytes are loaded into an internal store, then each
// drawn character produces one result per glyph row (framebuffer byte address of the
// row's leftmost 32-bit pixel plus an 8-bit bitmap, set = white, clear = black) at the
// cursor cell; carriage return, line feed, loads and zero-height glyphs produce a single
// result without a write. Every result carries the cursor after the request. One request
// is handled at a time: it is accepted in S_IDLE, then the font store offset is reduced
// modulo the store size by a restoring unit in S_MOD. A draw then does its address and
// cursor arithmetic (S_MUL, S_BASE, S_CURS) and the first store read (S_PRE), then
// gives one glyph row per cycle from the store's single read port (S_EMIT) while the
// result side does not stall. A load goes on to S_WR and S_RESP, a carriage return or
// line feed to S_CURS and S_RESP, a zero-height glyph through the arithmetic states to
// S_RESP. Result stalls hold the current result. The user must write registers only
// while no request is in flight; the block does not enforce it. The configuration port
// is always ready. Store entries never loaded read back undefined.
module text_console_glyph_renderer_unit
    import tcgr_pkg::*;
#(
    parameter int FONT_STORE_BYTES = 8192,
    parameter int MAX_GLYPH_ROWS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    tcgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    tcgr_dpath #(
        .FONT_STORE_BYTES (FONT_STORE_BYTES),
        .MAX_GLYPH_ROWS   (MAX_GLYPH_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_item      (o_out_data)
    );

`ifndef NO_ASSERTIONS
    // results only while a request is in flight
    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result shown while input side idle");

    // an accepted request keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // taking the final result frees the input side
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last) |=> !o_in_stall)
        else $error("still busy after final result");

    // a no-write result is always the final one
    a_nowrite_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.write_valid) |-> o_out_data.last)
        else $error("no-write result not marked last");
`endif

endmodule
`default_nettype wire
